// ----- design/dtl_pkg.sv -----
package dtl_pkg;

  localparam int WORD_BITS  = 32;
  localparam int LOAD_BITS  = 40;
  localparam int CLOCK_BITS = 30;
  localparam int DIV_BITS   = 2 * WORD_BITS;
  // two restoring steps per cycle
  localparam int DIV_CYCLES = DIV_BITS / 2;

  localparam logic [CLOCK_BITS-1:0] CLOCK_RESET = 30'd125000000;

  localparam logic [1:0] OP_RESET = 2'd0;
  localparam logic [1:0] OP_RAW   = 2'd1;
  localparam logic [1:0] OP_FREQ  = 2'd2;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_RESET  = 2'd2;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [WORD_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0] strobe_kind;
    logic       data_bit;
    logic       last;
  } out_t;

  // queue entry between the front and the serializer
  typedef struct packed {
    logic                 is_reset;
    logic [WORD_BITS-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [CLOCK_BITS-1:0] rem;
    logic [DIV_BITS-1:0]   quo;
  } div_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SHIFT,
    B_UPDATE,
    B_RESET
  } back_state_t;

  // one restoring division step; dividend bits leave at the top of quo,
  // quotient bits enter at the bottom
  function automatic div_t div_step(input div_t s, input logic [CLOCK_BITS-1:0] d);
    logic [CLOCK_BITS:0] r2;
    logic [CLOCK_BITS:0] diff;
    logic                ge;
    div_t                o;
    r2 = {s.rem, s.quo[DIV_BITS-1]};
    diff = r2 - {1'b0, d};
    ge = (r2 >= {1'b0, d});
    o.rem = ge ? diff[CLOCK_BITS-1:0] : r2[CLOCK_BITS-1:0];
    o.quo = {s.quo[DIV_BITS-2:0], ge};
    return o;
  endfunction

endpackage

// ----- design/dtl_fifo.sv -----
module dtl_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/dtl_front.sv -----
module dtl_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  dtl_pkg::in_t                    in_cmd,
  output logic                            busy,
  input  logic [dtl_pkg::CLOCK_BITS-1:0]  dds_clock_hz,
  input  logic                            q_full,
  output logic                            q_push,
  output dtl_pkg::cmd_t                   q_data
);

  localparam int CNT_W = $clog2(dtl_pkg::DIV_CYCLES);

  dtl_pkg::front_state_t         state_r, state_nxt;
  dtl_pkg::div_t                 div_r, div_nxt;
  logic [dtl_pkg::CLOCK_BITS-1:0] divisor_r, divisor_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          accept;

  assign accept = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtl_pkg::F_IDLE: begin
        if (accept && in_cmd.opcode == dtl_pkg::OP_FREQ) begin
          state_nxt = dtl_pkg::F_DIV;
        end
      end
      dtl_pkg::F_DIV: begin
        if (cnt_r == CNT_W'(dtl_pkg::DIV_CYCLES - 1)) begin
          state_nxt = dtl_pkg::F_PUSH;
        end
      end
      dtl_pkg::F_PUSH: begin
        if (!q_full) begin
          state_nxt = dtl_pkg::F_IDLE;
        end
      end
      default: state_nxt = dtl_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy          = 1'b1;
    q_push        = 1'b0;
    q_data        = '0;
    case (state_r)
      dtl_pkg::F_IDLE: begin
        busy = q_full;
        q_data.is_reset = (in_cmd.opcode == dtl_pkg::OP_RESET);
        q_data.word     = in_cmd.value;
        q_push = accept &&
                 (in_cmd.opcode == dtl_pkg::OP_RESET || in_cmd.opcode == dtl_pkg::OP_RAW);
      end
      dtl_pkg::F_PUSH: begin
        q_data.word = div_r.quo[dtl_pkg::WORD_BITS-1:0];
        q_push      = !q_full;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // divider datapath
  always_comb begin
    div_nxt     = div_r;
    divisor_nxt = divisor_r;
    cnt_nxt     = cnt_r;
    if (state_r == dtl_pkg::F_IDLE) begin
      div_nxt.rem = '0;
      div_nxt.quo = {in_cmd.value, {dtl_pkg::WORD_BITS{1'b0}}};
      divisor_nxt = dds_clock_hz;
      cnt_nxt     = '0;
    end else if (state_r == dtl_pkg::F_DIV) begin
      div_nxt = dtl_pkg::div_step(dtl_pkg::div_step(div_r, divisor_r), divisor_r);
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtl_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r     <= div_nxt;
    divisor_r <= divisor_nxt;
    cnt_r     <= cnt_nxt;
  end

endmodule

// ----- design/dtl_back.sv -----
module dtl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  dtl_pkg::cmd_t  q_head,
  output logic           q_pop,
  output logic           out_strobe,
  output dtl_pkg::out_t  out_res
);

  localparam int CNT_W = $clog2(dtl_pkg::LOAD_BITS);

  dtl_pkg::back_state_t          state_r, state_nxt;
  logic [dtl_pkg::WORD_BITS-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          out_strobe_r, out_strobe_nxt;
  dtl_pkg::out_t                 out_res_r, out_res_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dtl_pkg::B_SHIFT: begin
        if (cnt_r == CNT_W'(dtl_pkg::LOAD_BITS - 1)) begin
          state_nxt = dtl_pkg::B_UPDATE;
        end
      end
      dtl_pkg::B_IDLE, dtl_pkg::B_UPDATE, dtl_pkg::B_RESET: begin
        if (!q_empty) begin
          state_nxt = q_head.is_reset ? dtl_pkg::B_RESET : dtl_pkg::B_SHIFT;
        end else begin
          state_nxt = dtl_pkg::B_IDLE;
        end
      end
      default: state_nxt = dtl_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop          = 1'b0;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = '0;
    case (state_r)
      dtl_pkg::B_IDLE: begin
        q_pop = !q_empty;
      end
      dtl_pkg::B_SHIFT: begin
        out_strobe_nxt          = 1'b1;
        out_res_nxt.strobe_kind = dtl_pkg::KIND_DATA;
        out_res_nxt.data_bit    = word_r[0];
      end
      dtl_pkg::B_UPDATE: begin
        q_pop                   = !q_empty;
        out_strobe_nxt          = 1'b1;
        out_res_nxt.strobe_kind = dtl_pkg::KIND_UPDATE;
        out_res_nxt.last        = 1'b1;
      end
      dtl_pkg::B_RESET: begin
        q_pop                   = !q_empty;
        out_strobe_nxt          = 1'b1;
        out_res_nxt.strobe_kind = dtl_pkg::KIND_RESET;
        out_res_nxt.last        = 1'b1;
      end
      default: q_pop = 1'b0;
    endcase
  end

  // word shifts out LSB first; zeros fill the control and phase bits
  always_comb begin
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    if (q_pop) begin
      word_nxt = q_head.word;
      cnt_nxt  = '0;
    end else if (state_r == dtl_pkg::B_SHIFT) begin
      word_nxt = {1'b0, word_r[dtl_pkg::WORD_BITS-1:1]};
      cnt_nxt  = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dtl_pkg::B_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    cnt_r     <= cnt_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

// ----- design/dds_tuning_word_serial_loader.sv -----
// Serial loader for a 40-bit DDS. A command is taken when start is high and
// busy is low. A reset command gives one reset-pulse result; a load gives 40
// data-bit results (tuning word LSB first, then eight zero bits) and one
// update pulse, one result per cycle. Results appear on out_strobe/out_res
// for a single cycle each and cannot be held off. A frequency command first
// runs the 64/30-bit restoring divider in the front end, two quotient bits
// per cycle, and then queues the word; this overlaps with the serializer
// draining earlier commands through a QUEUE_DEPTH-entry queue. Sustained
// throughput is set by the serializer; busy is high while the divider works
// or waits to queue its word, or while the queue is full. cfg_ready is
// always high; write dds_clock_hz only while no command is in flight.
module dds_tuning_word_serial_loader #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  dtl_pkg::in_t                    in_cmd,
  output logic                            out_strobe,
  output dtl_pkg::out_t                   out_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dtl_pkg::CLOCK_BITS-1:0]  cfg_data
);

  logic [dtl_pkg::CLOCK_BITS-1:0] dds_clock_r;
  logic                           q_push, q_pop, q_full, q_empty;
  dtl_pkg::cmd_t                  q_data, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dds_clock_r <= dtl_pkg::CLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dds_clock_r <= cfg_data;
    end
  end

  dtl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_cmd       (in_cmd),
    .busy         (busy),
    .dds_clock_hz (dds_clock_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  dtl_fifo #(
    .WIDTH ($bits(dtl_pkg::cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  dtl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  a_last_on_pulse : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_res.last == (out_res.strobe_kind != dtl_pkg::KIND_DATA)))
    else $error("last flag does not match result kind");

  a_pulse_data_low : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.strobe_kind != dtl_pkg::KIND_DATA |-> !out_res.data_bit)
    else $error("data line high on a pulse result");

  a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_freq_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd.opcode == dtl_pkg::OP_FREQ |=> busy)
    else $error("front end free while dividing");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import dtl_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         DRAIN_CYCLES = 150;
  localparam int         CYCLE_LIMIT  = 500000;
  localparam int         PHASE_ITEMS  = 48;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_t                   in_cmd    = '0;
  logic                  out_strobe;
  out_t                  out_res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CLOCK_BITS-1:0] cfg_data  = '0;

  // model copy of the clock register
  logic [CLOCK_BITS-1:0] dds_clk_model = CLOCK_RESET;

  in_t  cmd_backlog[$];
  out_t pulse_q[$];
  in_t  held_cmd;
  logic drv_go;
  int   gap_left     = 0;
  int   n_queued     = 0;
  int   n_accepted   = 0;
  int   n_errors     = 0;
  int   cycles       = 0;
  bit   quiet        = 1'b0;

  dds_tuning_word_serial_loader DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .out_strobe(out_strobe),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [WORD_BITS-1:0] tuning_word(input logic [WORD_BITS-1:0] freq_hz);
    logic [63:0] num;
    logic [63:0] quo;
    if (dds_clk_model == '0) return '1;
    num = {freq_hz, 32'd0};
    quo = num / {34'd0, dds_clk_model};
    return quo[WORD_BITS-1:0];
  endfunction

  function automatic out_t mk_pulse(input logic [1:0] kind, input logic bit_val,
                                    input logic fin);
    out_t p;
    p.strobe_kind = kind;
    p.data_bit    = bit_val;
    p.last        = fin;
    return p;
  endfunction

  function automatic void expect_pulses(input in_t cmd);
    logic [WORD_BITS-1:0] word;
    case (cmd.opcode)
      OP_RESET: begin
        pulse_q.push_back(mk_pulse(KIND_RESET, 1'b0, 1'b1));
      end
      OP_RAW, OP_FREQ: begin
        word = (cmd.opcode == OP_RAW) ? cmd.value : tuning_word(cmd.value);
        for (int k = 0; k < LOAD_BITS; k++)
          pulse_q.push_back(mk_pulse(KIND_DATA, (k < WORD_BITS) ? word[k] : 1'b0, 1'b0));
        pulse_q.push_back(mk_pulse(KIND_UPDATE, 1'b0, 1'b1));
      end
      default: ;  // unused opcode is dropped
    endcase
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1000);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      2: return 32'd1 << $urandom_range(0, 31);
      3: return $urandom_range(0, 30000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(input logic [1:0] op, input logic [WORD_BITS-1:0] val);
    in_t c;
    c.opcode = op;
    c.value  = val;
    cmd_backlog.push_back(c);
    n_queued++;
  endtask

  task automatic queue_random(input int count);
    int          n;
    int          pick;
    logic [1:0]  op;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) op = OP_RESET;
      else if (pick < 3) op = OP_UNUSED;
      else if (pick < 10) op = OP_RAW;
      else op = OP_FREQ;
      queue_cmd(op, rand_value());
      if (op != OP_UNUSED) n++;
    end
  endtask

  // every queued command taken and every pulse seen, then let the pipe drain
  task automatic wait_idle();
    do @(posedge clk); while (n_accepted != n_queued || pulse_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_clock(input logic [CLOCK_BITS-1:0] hz);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= hz;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dds_clk_model = hz;
  endtask

  // driver: one command held on in_cmd until start && !busy
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      drv_go = start;
      if (start && !busy) begin
        expect_pulses(held_cmd);
        n_accepted++;
        drv_go = 1'b0;
      end
      if (!drv_go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 8) - 1;
        end else if (cmd_backlog.size() != 0) begin
          held_cmd = cmd_backlog.pop_front();
          drv_go   = 1'b1;
          in_cmd  <= held_cmd;
        end
      end
      start <= drv_go;
    end
  end

  // monitor: each strobe is one transaction, taken at the edge ending its cycle
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_strobe) begin
      if (pulse_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected pulse, expected none, actual kind=%0d bit=%0d last=%0d",
                 $time, out_res.strobe_kind, out_res.data_bit, out_res.last);
      end else begin
        want = pulse_q.pop_front();
        if (out_res.strobe_kind !== want.strobe_kind) begin
          n_errors++;
          $display("%0t: strobe_kind expected %0d actual %0d",
                   $time, want.strobe_kind, out_res.strobe_kind);
        end
        if (out_res.data_bit !== want.data_bit) begin
          n_errors++;
          $display("%0t: data_bit expected %0d actual %0d",
                   $time, want.data_bit, out_res.data_bit);
        end
        if (out_res.last !== want.last) begin
          n_errors++;
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_res.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [CLOCK_BITS-1:0] clk_plan[7];
    clk_plan[0] = 30'd1;
    clk_plan[1] = 30'd0;
    clk_plan[2] = 30'h3FFF_FFFF;
    clk_plan[3] = 30'd1000000000;
    clk_plan[4] = CLOCK_BITS'($urandom_range(1, 1000000000));
    clk_plan[5] = CLOCK_BITS'($urandom);
    clk_plan[6] = CLOCK_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at the reset clock value
    queue_cmd(OP_RESET, 32'd0);
    queue_cmd(OP_RAW, 32'd0);
    queue_cmd(OP_RAW, 32'hFFFF_FFFF);
    queue_cmd(OP_RAW, 32'h5555_AAAA);
    queue_cmd(OP_RAW, 32'h8000_0001);
    queue_cmd(OP_FREQ, 32'd0);
    queue_cmd(OP_FREQ, 32'd1);
    queue_cmd(OP_FREQ, 32'd15000);
    queue_cmd(OP_FREQ, 32'd62500000);
    queue_cmd(OP_FREQ, 32'd125000000);   // exactly 2^32, wraps to zero
    queue_cmd(OP_FREQ, 32'hFFFF_FFFF);   // quotient far past 32 bits
    queue_cmd(OP_UNUSED, 32'hFFFF_FFFF);
    queue_cmd(OP_RESET, 32'hFFFF_FFFF);
    queue_cmd(OP_UNUSED, 32'd0);
    queue_cmd(OP_RAW, 32'h0000_0001);
    queue_random(PHASE_ITEMS);

    for (int ph = 0; ph < 7; ph++) begin
      write_clock(clk_plan[ph]);
      if (ph == 6) quiet = 1'b1;
      queue_cmd(OP_FREQ, 32'hFFFF_FFFF);
      queue_cmd(OP_FREQ, {2'b00, clk_plan[ph]});
      queue_random(PHASE_ITEMS);
    end

    wait_idle();
    if (pulse_q.size() != 0) begin
      n_errors++;
      $display("%0t: %0d pulses expected but never seen", $time, pulse_q.size());
    end
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/dtl_pkg.sv
design/dtl_fifo.sv
design/dtl_front.sv
design/dtl_back.sv
design/dds_tuning_word_serial_loader.sv
dv/testbench.sv
